/* sv/hufd_pkg.sv */
`default_nettype none
package hufd_pkg;

  // input word kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DATA  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam int SYM_W     = 8;
  localparam int LEN_W     = 6;
  localparam int CODE_W    = 32;
  localparam int MSG_W     = 32;
  localparam int IDX_IN_W  = 8;
  localparam int DWORD_W   = 64;
  localparam int IN_DATA_W = 152;
  // common widths for code (CMP_W) and length (LCMP_W) compares
  localparam int CMP_W     = 64;
  localparam int LCMP_W    = 8;

  // one table entry as held in the RAM
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  // one decoded result
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_PUSH,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

/* sv/hufd_ram.sv */
`default_nettype none
module hufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/hufd_outbuf.sv */
`default_nettype none
module hufd_outbuf (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire hufd_pkg::res_t            res,
  output logic                           free,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [hufd_pkg::SYM_W-1:0]     out_tdata,  // symbol[7:0]
  output logic                           out_tlast
);

  logic            vld_r, vld_nxt;
  hufd_pkg::res_t  res_r;

  // register frees when empty or being drained this cycle
  assign free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (out_tready) vld_nxt = 1'b0;
    if (push) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) res_r <= res;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = res_r.sym;
  assign out_tlast  = res_r.last;

endmodule
`default_nettype wire

/* sv/huffman_table_decoder.sv */
`default_nettype none
// Table driven Huffman decoder.
// in_* carries one word per item; in_tuser selects the kind: load a table
// entry, a data word of code bits (most significant bit first), or start a
// message (clears pending bits, sets the message bit count).
// out_* returns each decoded symbol in turn; out_tlast marks the last symbol
// produced by a given data word.
// A data word is decoded one bit at a time: each bit is followed by a scan
// of the table RAM, one entry per cycle, that ends at the first matching
// entry or after the last entry is checked. The single RAM read port limits
// the scan to one entry at a time.
// Symbols go through an output register plus one pending symbol, so decoding
// runs on while one result waits; a stalled receiver halts the decoder once
// a third symbol is ready. in_tready is high only between items.
// Reset clears all entry valid bits and the message state; table contents
// are left as they are and are ignored while invalid.
module huffman_table_decoder #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_BITS = 32,
  parameter int WORD_BITS     = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // entry_index[7:0] entry_symbol[15:8] entry_code[47:16] entry_length[53:48]
  // data_word[117:54] message_bits[149:118], zero pad to 152
  input  wire logic [hufd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]                      in_tuser,  // op[1:0]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [hufd_pkg::SYM_W-1:0]           out_tdata, // symbol[7:0]
  output logic                                 out_tlast
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int PLW   = $clog2(MAX_CODE_BITS + 1);
  localparam int BCW   = $clog2(WORD_BITS + 1);

  // unpack input word
  logic [hufd_pkg::IDX_IN_W-1:0] f_idx;
  logic [hufd_pkg::SYM_W-1:0]    f_sym;
  logic [hufd_pkg::CODE_W-1:0]   f_code;
  logic [hufd_pkg::LEN_W-1:0]    f_len;
  logic [hufd_pkg::DWORD_W-1:0]  f_word;
  logic [hufd_pkg::MSG_W-1:0]    f_msg;
  hufd_pkg::op_t                 f_op;

  assign f_idx  = in_tdata[7:0];
  assign f_sym  = in_tdata[15:8];
  assign f_code = in_tdata[47:16];
  assign f_len  = in_tdata[53:48];
  assign f_word = in_tdata[117:54];
  assign f_msg  = in_tdata[149:118];
  assign f_op   = hufd_pkg::op_t'(in_tuser);

  hufd_pkg::state_t              state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0]      valid_r, valid_nxt;
  logic [MAX_CODE_BITS-1:0]      pcode_r, pcode_nxt;
  logic [PLW-1:0]                plen_r, plen_nxt;
  logic [hufd_pkg::MSG_W-1:0]    left_r, left_nxt;
  logic                          stop_r, stop_nxt;
  logic [WORD_BITS-1:0]          word_r, word_nxt;
  logic [BCW-1:0]                brem_r, brem_nxt;
  logic [CNT_W-1:0]              rd_r, rd_nxt;
  logic                          cv_r, cv_nxt;
  logic [IDX_W-1:0]              ci_r, ci_nxt;
  logic [hufd_pkg::LEN_W-1:0]    max_r, max_nxt;
  logic                          pv_r, pv_nxt;
  logic [hufd_pkg::SYM_W-1:0]    ps_r, ps_nxt;
  logic [hufd_pkg::SYM_W-1:0]    hs_r, hs_nxt;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr, ram_raddr;
  hufd_pkg::entry_t              ram_wdata, ram_rdata;
  logic                          ob_push, ob_free;
  hufd_pkg::res_t                ob_res;
  logic                          accept, hit, idx_ok;
  logic [hufd_pkg::CODE_W-1:0]   lmask;

  assign accept = in_tvalid && in_tready;
  assign idx_ok = ({1'b0, f_idx} < 9'(TABLE_ENTRIES));

  // low mask of the loaded code length
  assign lmask = (f_len >= hufd_pkg::LEN_W'(hufd_pkg::CODE_W)) ? '1 :
                 ((hufd_pkg::CODE_W'(1) << f_len) - hufd_pkg::CODE_W'(1));

  assign ram_we    = accept && (f_op == hufd_pkg::OP_LOAD) && idx_ok;
  assign ram_waddr = f_idx[IDX_W-1:0];
  assign ram_wdata = '{sym: f_sym, len: f_len, code: f_code & lmask};
  assign ram_raddr = rd_r[IDX_W-1:0];

  // match of the entry read last cycle against the gathered bits
  assign hit = cv_r && valid_r[ci_r]
            && (hufd_pkg::LCMP_W'(ram_rdata.len) == hufd_pkg::LCMP_W'(plen_r))
            && (hufd_pkg::CMP_W'(ram_rdata.code) == hufd_pkg::CMP_W'(pcode_r));

  hufd_ram #(
    .WIDTH ($bits(hufd_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hufd_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ob_push),
    .res        (ob_res),
    .free       (ob_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // control and decode datapath
  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    pcode_nxt = pcode_r;
    plen_nxt  = plen_r;
    left_nxt  = left_r;
    stop_nxt  = stop_r;
    word_nxt  = word_r;
    brem_nxt  = brem_r;
    rd_nxt    = rd_r;
    cv_nxt    = 1'b0;
    ci_nxt    = ci_r;
    max_nxt   = max_r;
    pv_nxt    = pv_r;
    ps_nxt    = ps_r;
    hs_nxt    = hs_r;
    ob_push   = 1'b0;
    ob_res    = '{sym: ps_r, last: 1'b0};
    in_tready = 1'b0;
    case (state_r)
      hufd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          case (f_op)
            hufd_pkg::OP_LOAD: begin
              if (idx_ok) begin
                valid_nxt[f_idx[IDX_W-1:0]] = (f_len >= hufd_pkg::LEN_W'(1))
                  && (hufd_pkg::LCMP_W'(f_len) <= hufd_pkg::LCMP_W'(MAX_CODE_BITS));
              end
            end
            hufd_pkg::OP_START: begin
              pcode_nxt = '0;
              plen_nxt  = '0;
              left_nxt  = f_msg;
              stop_nxt  = 1'b0;
            end
            hufd_pkg::OP_DATA: begin
              word_nxt  = f_word[WORD_BITS-1:0];
              brem_nxt  = BCW'(WORD_BITS);
              state_nxt = hufd_pkg::ST_BIT;
            end
            default: ;
          endcase
        end
      end
      hufd_pkg::ST_BIT: begin
        if (stop_r || left_r == '0 || brem_r == '0) begin
          state_nxt = hufd_pkg::ST_FLUSH;
        end else begin
          left_nxt  = left_r - hufd_pkg::MSG_W'(1);
          brem_nxt  = brem_r - BCW'(1);
          pcode_nxt = {pcode_r[MAX_CODE_BITS-2:0], word_r[WORD_BITS-1]};
          plen_nxt  = plen_r + PLW'(1);
          word_nxt  = word_r << 1;
          rd_nxt    = '0;
          max_nxt   = '0;
          state_nxt = hufd_pkg::ST_SCAN;
        end
      end
      hufd_pkg::ST_SCAN: begin
        // issue next read
        if (rd_r < CNT_W'(TABLE_ENTRIES)) begin
          cv_nxt = 1'b1;
          ci_nxt = rd_r[IDX_W-1:0];
          rd_nxt = rd_r + CNT_W'(1);
        end
        // check returned entry
        if (hit) begin
          cv_nxt    = 1'b0;
          hs_nxt    = ram_rdata.sym;
          pcode_nxt = '0;
          plen_nxt  = '0;
          state_nxt = hufd_pkg::ST_PUSH;
        end else begin
          if (cv_r && valid_r[ci_r] && ram_rdata.len > max_r) begin
            max_nxt = ram_rdata.len;
          end
          if (!cv_r && rd_r == CNT_W'(TABLE_ENTRIES)) begin
            if (hufd_pkg::LCMP_W'(plen_r) >= hufd_pkg::LCMP_W'(max_r)) begin
              pcode_nxt = '0;
              plen_nxt  = '0;
              stop_nxt  = 1'b1;
            end
            state_nxt = hufd_pkg::ST_BIT;
          end
        end
      end
      hufd_pkg::ST_PUSH: begin
        // older symbol is not the last of this word
        if (!pv_r || ob_free) begin
          ob_push   = pv_r;
          pv_nxt    = 1'b1;
          ps_nxt    = hs_r;
          state_nxt = hufd_pkg::ST_BIT;
        end
      end
      hufd_pkg::ST_FLUSH: begin
        ob_res = '{sym: ps_r, last: 1'b1};
        if (!pv_r || ob_free) begin
          ob_push   = pv_r;
          pv_nxt    = 1'b0;
          state_nxt = hufd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hufd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hufd_pkg::ST_IDLE;
      valid_r <= '0;
      pcode_r <= '0;
      plen_r  <= '0;
      left_r  <= '0;
      stop_r  <= 1'b0;
      cv_r    <= 1'b0;
      pv_r    <= 1'b0;
      rd_r    <= '0;
      brem_r  <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      pcode_r <= pcode_nxt;
      plen_r  <= plen_nxt;
      left_r  <= left_nxt;
      stop_r  <= stop_nxt;
      cv_r    <= cv_nxt;
      pv_r    <= pv_nxt;
      rd_r    <= rd_nxt;
      brem_r  <= brem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    ci_r   <= ci_nxt;
    max_r  <= max_nxt;
    ps_r   <= ps_nxt;
    hs_r   <= hs_nxt;
  end

  // no symbol may be held back once the word is done
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hufd_pkg::ST_IDLE) |-> !pv_r)
    else $error("pending symbol left in idle");

  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hufd_pkg::LCMP_W'(plen_r) <= hufd_pkg::LCMP_W'(MAX_CODE_BITS))
    else $error("gathered code longer than max code length");

  a_hit_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hufd_pkg::ST_SCAN && hit) |=> (state_r == hufd_pkg::ST_PUSH && plen_r == '0))
    else $error("match did not lead to push");

endmodule
`default_nettype wire

/* sim/huffman_table_decoder_tb.sv */
`default_nettype none
module huffman_table_decoder_tb;

  // one input word as the sender sees it
  typedef struct {
    hufd_pkg::op_t op;
    logic [7:0]  idx;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
    logic [63:0] word;
    logic [31:0] msg;
    bit          chk;    // typed-in expectation present
    int          n_exp;
    logic [7:0]  first_exp;
  } stim_t;

  typedef struct {
    logic [7:0] sym;
    logic       last;
  } sym_exp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  wire logic    in_tready;
  logic [hufd_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0]   in_tuser = 2'b0;
  wire logic    out_tvalid;
  logic         out_tready = 1'b0;
  wire logic [hufd_pkg::SYM_W-1:0] out_tdata;
  wire logic    out_tlast;

  huffman_table_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  // decoder model state
  logic [31:0] tbl_code [256];
  logic [5:0]  tbl_len  [256];
  logic [7:0]  tbl_sym  [256];
  bit          tbl_ok   [256];
  logic [63:0] part_code;
  int          part_len;
  logic [31:0] bits_left;
  bit          halted;

  sym_exp_t symbol_q[$];
  int mismatches = 0;
  int words_sent = 0, loads_sent = 0, data_sent = 0, starts_sent = 0;
  int symbols_seen = 0;
  bit stim_done = 1'b0;

  function automatic logic [63:0] low_bits(int n);
    if (n >= 64) return '1;
    return (64'h1 << n) - 64'h1;
  endfunction

  // apply one word to the model, queue the symbols it decodes
  task automatic decode_word(input stim_t s, output int n, output logic [7:0] first);
    int longest;
    int i;
    int hit;
    n = 0;
    first = '0;
    case (s.op)
      hufd_pkg::OP_LOAD: begin
        tbl_sym[s.idx]  = s.sym;
        tbl_len[s.idx]  = s.len;
        tbl_code[s.idx] = 32'({32'h0, s.code} & low_bits(s.len));
        tbl_ok[s.idx]   = (s.len >= 1 && s.len <= 32);
      end
      hufd_pkg::OP_START: begin
        part_code = '0;
        part_len  = 0;
        bits_left = s.msg;
        halted    = 1'b0;
      end
      hufd_pkg::OP_DATA: begin
        longest = 0;
        for (i = 0; i < 256; i++)
          if (tbl_ok[i] && tbl_len[i] > longest) longest = int'(tbl_len[i]);
        for (int pos = 63; pos >= 0; pos--) begin
          if (halted || bits_left == 0) break;
          bits_left--;
          part_code = {part_code[62:0], s.word[pos]};
          part_len++;
          hit = -1;
          for (i = 0; i < 256; i++)
            if (tbl_ok[i] && tbl_len[i] == part_len &&
                {32'h0, tbl_code[i]} == (part_code & low_bits(part_len))) begin
              hit = i;
              break;
            end
          if (hit >= 0) begin
            if (n == 0) first = tbl_sym[hit];
            symbol_q.insert(symbol_q.size(), '{sym: tbl_sym[hit], last: 1'b0});
            n++;
            part_code = '0;
            part_len  = 0;
          end else if (part_len >= longest) begin
            // dead end: nothing longer can match
            part_code = '0;
            part_len  = 0;
            halted    = 1'b1;
          end
        end
        if (n > 0) symbol_q[symbol_q.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one word, wait for the handshake, then predict and maybe pause
  task automatic send(input stim_t s);
    int n;
    int gap;
    logic [7:0] first;
    in_tvalid <= 1'b1;
    in_tuser  <= s.op;
    in_tdata  <= {2'b00, s.msg, s.word, s.len, s.code, s.sym, s.idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_word(s, n, first);
    words_sent++;
    case (s.op)
      hufd_pkg::OP_LOAD:  loads_sent++;
      hufd_pkg::OP_DATA:  data_sent++;
      hufd_pkg::OP_START: starts_sent++;
      default: ;
    endcase
    if (s.chk && (n != s.n_exp || (n > 0 && first != s.first_exp))) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row %0d: expected %0d symbols first %h, model gives %0d first %h",
                 words_sent, s.n_exp, s.first_exp, n, first);
    end
    gap = (words_sent >= 120 && words_sent < 160) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic stim_t mk_load(logic [7:0] idx, logic [7:0] sym, logic [31:0] code,
                                    logic [5:0] len);
    stim_t s;
    s = '{op: hufd_pkg::OP_LOAD, idx: idx, sym: sym, code: code, len: len,
          word: 64'($urandom), msg: $urandom, chk: 1'b0, n_exp: 0, first_exp: 8'h00};
    return s;
  endfunction

  function automatic stim_t mk_data(logic [63:0] word);
    stim_t s;
    s = '{op: hufd_pkg::OP_DATA, idx: 8'($urandom), sym: 8'($urandom), code: $urandom,
          len: 6'($urandom), word: word, msg: $urandom, chk: 1'b0, n_exp: 0,
          first_exp: 8'h00};
    return s;
  endfunction

  function automatic stim_t mk_start(logic [31:0] msg);
    stim_t s;
    s = mk_data(64'($urandom));
    s.op  = hufd_pkg::OP_START;
    s.msg = msg;
    return s;
  endfunction

  function automatic stim_t typed(stim_t s, int n, logic [7:0] first);
    s.chk = 1'b1;
    s.n_exp = n;
    s.first_exp = first;
    return s;
  endfunction

  // stimulus: directed table, then random messages
  initial begin
    stim_t dir[$];
    stim_t s;
    logic [31:0] lf_code [16];
    int          lf_len  [16];
    int          nleaf, j, k, drop;
    for (int i = 0; i < 256; i++) begin
      tbl_ok[i] = 0; tbl_code[i] = '0; tbl_len[i] = '0; tbl_sym[i] = '0;
    end
    part_code = '0; part_len = 0; bits_left = '0; halted = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    dir.insert(dir.size(), typed(mk_data('1), 0, 8'h00));          // data before start
    s = mk_data('1); s.op = hufd_pkg::OP_NONE; dir.insert(dir.size(), typed(s, 0, 8'h00));
    dir.insert(dir.size(), mk_load(8'd0, 8'h41, 32'h0, 6'd1));     // 0   -> A
    dir.insert(dir.size(), mk_load(8'd1, 8'h42, 32'h2, 6'd2));     // 10  -> B
    dir.insert(dir.size(), mk_load(8'd2, 8'h43, 32'h3, 6'd2));     // 11  -> C
    dir.insert(dir.size(), mk_load(8'd3, 8'hFF, 32'h0, 6'd1));     // duplicate, loses to slot 0
    dir.insert(dir.size(), mk_load(8'd255, 8'h00, 32'hFFFF_FFFF, 6'd32));
    dir.insert(dir.size(), mk_load(8'd254, 8'h55, 32'h1, 6'd0));   // zero length
    dir.insert(dir.size(), mk_load(8'd253, 8'hAA, 32'hFFFF_FFFF, 6'd63)); // too long
    dir.insert(dir.size(), mk_load(8'd4, 8'h44, 32'hFFFF_FFFF, 6'd3)); // high code bits masked
    dir.insert(dir.size(), mk_start(32'd64));
    dir.insert(dir.size(), typed(mk_data(64'h0), 64, 8'h41));      // every bit a symbol
    dir.insert(dir.size(), mk_start(32'd0));
    dir.insert(dir.size(), typed(mk_data(64'h0), 0, 8'h00));       // all padding
    dir.insert(dir.size(), mk_start(32'hFFFF_FFFF));
    dir.insert(dir.size(), typed(mk_data('1), 32, 8'h43));
    dir.insert(dir.size(), typed(mk_data(64'h8000_0000_0000_0000), 63, 8'h42));
    dir.insert(dir.size(), mk_start(32'd1));
    dir.insert(dir.size(), typed(mk_data(64'h8000_0000_0000_0000), 0, 8'h00)); // ends inside a code
    dir.insert(dir.size(), mk_load(8'd255, 8'h00, 32'h0, 6'd0));
    dir.insert(dir.size(), mk_load(8'd0, 8'h41, 32'h0, 6'd0));
    dir.insert(dir.size(), mk_load(8'd3, 8'hFF, 32'h0, 6'd0));     // no code starts with 0 now
    dir.insert(dir.size(), mk_start(32'd100));
    dir.insert(dir.size(), typed(mk_data(64'h0), 0, 8'h00));       // dead end, halts
    dir.insert(dir.size(), typed(mk_data('1), 0, 8'h00));          // still halted
    dir.insert(dir.size(), mk_start(32'd4));
    dir.insert(dir.size(), typed(mk_data(64'hC000_0000_0000_0000), 1, 8'h43));
    foreach (dir[i]) send(dir[i]);

    // random messages over random prefix codes
    while (words_sent < 260) begin
      if ($urandom_range(0, 5) == 0 || words_sent < 30) begin
        lf_code[0] = 0; lf_len[0] = 1;
        lf_code[1] = 1; lf_len[1] = 1;
        nleaf = 2;
        k = $urandom_range(0, 9);
        repeat (k) begin
          j = $urandom_range(0, nleaf - 1);
          if (lf_len[j] < 10) begin
            lf_code[nleaf] = {lf_code[j][30:0], 1'b1};
            lf_len[nleaf]  = lf_len[j] + 1;
            lf_code[j]     = {lf_code[j][30:0], 1'b0};
            lf_len[j]      = lf_len[j] + 1;
            nleaf++;
          end
        end
        // now and then leave one leaf out so a dead end can be hit
        drop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nleaf - 1) : -1;
        for (int i = 0; i < nleaf; i++)
          send(mk_load(8'(i), 8'($urandom),
                       i == drop ? 32'($urandom) : (lf_code[i] | ($urandom << lf_len[i])),
                       i == drop ? 6'd0 : 6'(lf_len[i])));
      end
      // noise: stray loads, unknown kinds, bare data
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: send(mk_load(8'($urandom), 8'($urandom), $urandom, 6'($urandom)));
          1: begin
            s = mk_data({$urandom, $urandom}); s.op = hufd_pkg::OP_NONE; send(s);
          end
          default: send(mk_data({$urandom, $urandom}));
        endcase
      end
      send(mk_start($urandom_range(0, 19) == 0 ? $urandom : $urandom_range(1, 160)));
      repeat ($urandom_range(1, 3)) send(mk_data({$urandom, $urandom}));
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int gap;
    bit held;
    held = 0;
    wait (rst_n);
    forever begin
      out_tready <= 1'b1;
      @(posedge clk);
      if (!held && symbols_seen >= 40) begin
        held = 1;
        out_tready <= 1'b0;
        for (int c = 0; c < 3000; c++) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // compare each delivered symbol with the oldest expected one
  always @(posedge clk) begin
    sym_exp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      symbols_seen++;
      if (symbol_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected symbol %h last %b", out_tdata, out_tlast);
      end else begin
        e = symbol_q.pop_front();
        if (out_tdata !== e.sym || out_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("symbol mismatch: expected %h last %b, got %h last %b",
                     e.sym, e.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (symbol_q.size() != 0) @(posedge clk);
    repeat (17000) @(posedge clk);
    $display("sent %0d words: %0d loads, %0d starts, %0d data words",
             words_sent, loads_sent, starts_sent, data_sent);
    $display("checked %0d decoded symbols, %0d mismatches", symbols_seen, mismatches);
    if (mismatches == 0 && symbol_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #240000000;
    $display("timeout with %0d symbols outstanding", symbol_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
